// ----- rtl/core/qesm_pkg.sv -----
// shared constants and widths for the quadrature encoder speed meter
package qesm_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int POS_W        = 32;
	localparam int RATE_W       = 16;
	localparam int KEEP_W       = 9;
	localparam int MASK_W       = 4;
	localparam int FILT_W       = 40;
	localparam int MUL_A_W      = 40;
	localparam int MUL_B_W      = 17;
	localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
	localparam int ACC_W        = 50;
	localparam int Q_FRAC_W     = 8;

	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOWS_PER_MINUTE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_KEEP        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK        = 2'd3;

	localparam logic [RATE_W-1:0] PPR_RESET  = 16'd90;
	localparam logic [RATE_W-1:0] WPM_RESET  = 16'd300;
	localparam logic [KEEP_W-1:0] KEEP_RESET = 9'd179;
	localparam logic [MASK_W-1:0] INV_RESET  = 4'd12;
	localparam logic [KEEP_W-1:0] KEEP_FULL  = 9'd256;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

endpackage

// ----- rtl/core/qesm_if.sv -----
// item channels of the encoder speed meter: pin samples in, reports out
interface qesm_in_if;
	import qesm_pkg::*;

	logic              valid;
	logic              ready;
	logic              command;
	logic [MASK_W-1:0] phase_a;
	logic [MASK_W-1:0] phase_b;

	modport source (output valid, command, phase_a, phase_b, input ready);
	modport sink (input valid, command, phase_a, phase_b, output ready);
endinterface

interface qesm_out_if;
	import qesm_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] position_0;
	logic signed [POS_W-1:0] position_1;
	logic signed [POS_W-1:0] position_2;
	logic signed [POS_W-1:0] position_3;
	logic signed [POS_W-1:0] speed_0;
	logic signed [POS_W-1:0] speed_1;
	logic signed [POS_W-1:0] speed_2;
	logic signed [POS_W-1:0] speed_3;
	logic signed [POS_W-1:0] smoothed_0;
	logic signed [POS_W-1:0] smoothed_1;
	logic signed [POS_W-1:0] smoothed_2;
	logic signed [POS_W-1:0] smoothed_3;

	modport source (
		output valid, position_0, position_1, position_2, position_3,
		speed_0, speed_1, speed_2, speed_3,
		smoothed_0, smoothed_1, smoothed_2, smoothed_3,
		input ready
	);
	modport sink (
		input valid, position_0, position_1, position_2, position_3,
		speed_0, speed_1, speed_2, speed_3,
		smoothed_0, smoothed_1, smoothed_2, smoothed_3,
		output ready
	);
endinterface

// ----- rtl/core/qesm_div.sv -----
// bit-serial signed-by-unsigned divider, truncating quotient
module qesm_div #(
	parameter int WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [WIDTH-1:0]       dividend,
	input  logic [qesm_pkg::RATE_W-1:0]   divisor,
	output logic                          done,
	output logic signed [WIDTH-1:0]       quotient
);
	import qesm_pkg::*;

	localparam int CW = $clog2(WIDTH + 1);

	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [CW-1:0]     cnt_q;
	logic [RATE_W-1:0] rem_q;
	logic [WIDTH-1:0]  quo_q;

	logic [WIDTH-1:0]  mag;
	logic [RATE_W:0]   trial;
	logic [RATE_W:0]   diff;
	logic              fits;

	assign mag   = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
	assign trial = {rem_q, quo_q[WIDTH-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring step: one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[WIDTH-1];
			rem_q <= '0;
			quo_q <= mag;
		end else if (busy_q) begin
			rem_q <= fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
			quo_q <= {quo_q[WIDTH-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? signed'(~quo_q + 1'b1) : signed'(quo_q);

endmodule

// ----- rtl/core/qesm_mul.sv -----
// shared signed multiplier with registered product
module qesm_mul (
	input  logic                                clk,
	input  logic signed [qesm_pkg::MUL_A_W-1:0] a,
	input  logic signed [qesm_pkg::MUL_B_W-1:0] b,
	output logic signed [qesm_pkg::MUL_P_W-1:0] p
);
	import qesm_pkg::*;

	logic signed [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = p_q;

endmodule

// ----- rtl/core/quad_encoder_speed_meter.sv -----
// top level: four-channel x1 quadrature counter with rpm and filtered rpm
//
//   channel   dir   handshake        carries
//   items     in    valid/ready      command, phase_a, phase_b
//   results   out   valid/ready      position_0..3, speed_0..3, smoothed_0..3
//   wr_*      in    wr_en only       register index and data
//
// a pin sample item gives no result.
// a tick item runs the channels in turn: per channel the serial divider takes a
// load step, WINDOW_WIDTH steps and a done step, then the shared multiplier is
// used three times and the filter sum is written.
// items.ready is low from tick acceptance until the report is loaded; the report
// waits in its own register, so samples are taken while it is stalled.
// reset clears all counts and filter state and loads the register defaults.
module quad_encoder_speed_meter #(
	parameter int WINDOW_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	qesm_in_if.sink                         items,
	qesm_out_if.source                      results,
	input  logic                            wr_en,
	input  logic [qesm_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [qesm_pkg::CFG_DATA_W-1:0] wr_data
);
	import qesm_pkg::*;

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic signed [WINDOW_WIDTH-1:0] WIN_MAX = {1'b0, {(WINDOW_WIDTH-1){1'b1}}};
	localparam logic signed [WINDOW_WIDTH-1:0] WIN_MIN = {1'b1, {(WINDOW_WIDTH-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL_RPM,
		ST_SAT,
		ST_MUL_OLD,
		ST_MUL_NEW,
		ST_ADD,
		ST_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [RATE_W-1:0] ppr_q;
	logic [RATE_W-1:0] wpm_q;
	logic [KEEP_W-1:0] keep_q;
	logic [MASK_W-1:0] inv_q;

	// counting state
	logic [NUM_CHANNELS-1:0]        last_a_q;
	logic [POS_W-1:0]               pos_q [NUM_CHANNELS];
	logic signed [WINDOW_WIDTH-1:0] win_q [NUM_CHANNELS];
	logic signed [FILT_W-1:0]       filt_q [NUM_CHANNELS];
	logic signed [POS_W-1:0]        speed_q [NUM_CHANNELS];

	// sequencer
	logic [CH_W-1:0]           ch_q;
	logic                      div_start_q;
	logic signed [MUL_P_W-1:0] hold_q;

	// report register
	logic                    out_valid_q;
	logic signed [POS_W-1:0] out_pos_q [NUM_CHANNELS];
	logic signed [POS_W-1:0] out_spd_q [NUM_CHANNELS];
	logic signed [POS_W-1:0] out_smo_q [NUM_CHANNELS];

	logic                           accept;
	logic                           div_done;
	logic signed [WINDOW_WIDTH-1:0] div_quo;
	logic signed [MUL_A_W-1:0]      mul_a;
	logic signed [MUL_B_W-1:0]      mul_b;
	logic signed [MUL_P_W-1:0]      mul_p;
	logic [KEEP_W-1:0]              keep_eff;
	logic [KEEP_W-1:0]              keep_rest;
	logic signed [POS_W-1:0]        rpm_sat;
	logic signed [ACC_W-1:0]        acc;
	logic signed [ACC_W-Q_FRAC_W-1:0] acc_sh;
	logic signed [FILT_W-1:0]       filt_new;
	logic signed [FILT_W-1:0]       smo_adj [NUM_CHANNELS];
	logic                           out_free;

	assign accept    = items.valid && items.ready;
	assign items.ready = (state_q == ST_IDLE);
	assign keep_eff  = (keep_q > KEEP_FULL) ? KEEP_FULL : keep_q;
	assign keep_rest = KEEP_FULL - keep_eff;
	assign out_free  = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q  <= PPR_RESET;
			wpm_q  <= WPM_RESET;
			keep_q <= KEEP_RESET;
			inv_q  <= INV_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PULSES_PER_REV:     ppr_q  <= wr_data;
				REG_WINDOWS_PER_MINUTE: wpm_q  <= wr_data;
				REG_FILTER_KEEP:        keep_q <= wr_data[KEEP_W-1:0];
				REG_INVERT_MASK:        inv_q  <= wr_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// edge detection and counting on sample items; window cleared once read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				pos_q[i] <= '0;
				win_q[i] <= '0;
			end
		end else if (accept && items.command == CMD_SAMPLE) begin
			last_a_q <= items.phase_a[NUM_CHANNELS-1:0];
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (items.phase_a[i] && !last_a_q[i]) begin
					if (items.phase_b[i] ^ inv_q[i]) begin
						pos_q[i] <= pos_q[i] + 1'b1;
						if (win_q[i] != WIN_MAX)
							win_q[i] <= win_q[i] + 1'b1;
					end else begin
						pos_q[i] <= pos_q[i] - 1'b1;
						if (win_q[i] != WIN_MIN)
							win_q[i] <= win_q[i] - 1'b1;
					end
				end
			end
		end else if (state_q == ST_ADD) begin
			win_q[ch_q] <= '0;
		end
	end

	qesm_div #(
		.WIDTH (WINDOW_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (win_q[ch_q]),
		.divisor  (ppr_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = MUL_A_W'(div_quo);
		mul_b = signed'({1'b0, wpm_q});
		case (state_q)
			ST_MUL_OLD: begin
				mul_a = filt_q[ch_q];
				mul_b = signed'(MUL_B_W'(keep_eff));
			end
			ST_MUL_NEW: begin
				mul_a = MUL_A_W'(speed_q[ch_q]);
				mul_b = signed'(MUL_B_W'(keep_rest));
			end
			default: ;
		endcase
	end

	qesm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// rpm saturation to 32 bits; zero divisor reads as zero speed
	always_comb begin
		if (ppr_q == '0)
			rpm_sat = '0;
		else if (mul_p[MUL_P_W-1:POS_W-1] == '0 || mul_p[MUL_P_W-1:POS_W-1] == '1)
			rpm_sat = mul_p[POS_W-1:0];
		else
			rpm_sat = mul_p[MUL_P_W-1] ? signed'({1'b1, {(POS_W-1){1'b0}}})
				: signed'({1'b0, {(POS_W-1){1'b1}}});
	end

	// filter: old*keep + new*(256-keep)*256, floor by 256, clamp to 40 bits
	assign acc    = ACC_W'(hold_q) + (ACC_W'(mul_p) <<< Q_FRAC_W);
	assign acc_sh = acc[ACC_W-1:Q_FRAC_W];

	always_comb begin
		if (acc_sh[ACC_W-Q_FRAC_W-1:FILT_W-1] == '0 || acc_sh[ACC_W-Q_FRAC_W-1:FILT_W-1] == '1)
			filt_new = acc_sh[FILT_W-1:0];
		else
			filt_new = acc_sh[ACC_W-Q_FRAC_W-1] ? signed'({1'b1, {(FILT_W-1){1'b0}}})
				: signed'({1'b0, {(FILT_W-1){1'b1}}});
	end

	// truncate toward zero for the report
	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++)
			smo_adj[i] = filt_q[i] + (filt_q[i][FILT_W-1] ? FILT_W'(255) : FILT_W'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			hold_q      <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				filt_q[i]    <= '0;
				speed_q[i]   <= '0;
				out_pos_q[i] <= '0;
				out_spd_q[i] <= '0;
				out_smo_q[i] <= '0;
			end
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && results.ready && state_q != ST_OUT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && items.command == CMD_TICK) begin
						ch_q        <= '0;
						div_start_q <= 1'b1;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_MUL_RPM;
				end
				ST_MUL_RPM: state_q <= ST_SAT;
				ST_SAT: begin
					speed_q[ch_q] <= rpm_sat;
					state_q       <= ST_MUL_OLD;
				end
				ST_MUL_OLD: state_q <= ST_MUL_NEW;
				ST_MUL_NEW: begin
					hold_q  <= mul_p;
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					filt_q[ch_q] <= filt_new;
					if (ch_q == CH_W'(NUM_CHANNELS - 1)) begin
						state_q <= ST_OUT;
					end else begin
						ch_q        <= ch_q + 1'b1;
						div_start_q <= 1'b1;
						state_q     <= ST_DIV;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						for (int i = 0; i < NUM_CHANNELS; i++) begin
							out_pos_q[i] <= signed'(pos_q[i]);
							out_spd_q[i] <= speed_q[i];
							out_smo_q[i] <= smo_adj[i][FILT_W-1:Q_FRAC_W];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign results.valid      = out_valid_q;
	assign results.position_0 = out_pos_q[0];
	assign results.position_1 = out_pos_q[1];
	assign results.position_2 = out_pos_q[2];
	assign results.position_3 = out_pos_q[3];
	assign results.speed_0    = out_spd_q[0];
	assign results.speed_1    = out_spd_q[1];
	assign results.speed_2    = out_spd_q[2];
	assign results.speed_3    = out_spd_q[3];
	assign results.smoothed_0 = out_smo_q[0];
	assign results.smoothed_1 = out_smo_q[1];
	assign results.smoothed_2 = out_smo_q[2];
	assign results.smoothed_3 = out_smo_q[3];

endmodule

// ----- dv/quad_encoder_speed_meter_tb.sv -----
// testbench for the quad encoder speed meter: encoder motion, ticks and a report scoreboard
module quad_encoder_speed_meter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qesm_pkg::*;

	localparam int     WINDOW_BITS  = 16;
	localparam int     WIN_MAX      = (1 << (WINDOW_BITS - 1)) - 1;
	localparam int     WIN_MIN      = -WIN_MAX - 1;
	localparam int     DRAIN_CYCLES = 4 * (WINDOW_BITS + 6) + 30;
	localparam longint RPM_MAX      = 64'sd2147483647;
	localparam longint RPM_MIN      = -RPM_MAX - 1;
	localparam longint FILT_MAX     = (64'sd1 <<< (FILT_W - 1)) - 1;
	localparam longint FILT_MIN     = -FILT_MAX - 1;

	typedef struct packed {
		logic [NUM_CHANNELS-1:0][POS_W-1:0] position;
		logic [NUM_CHANNELS-1:0][POS_W-1:0] speed;
		logic [NUM_CHANNELS-1:0][POS_W-1:0] smoothed;
	} speed_report_t;

	class rpm_scoreboard;
		logic [RATE_W-1:0] pulses_per_rev;
		logic [RATE_W-1:0] windows_per_minute;
		logic [KEEP_W-1:0] filter_keep;
		logic [MASK_W-1:0] invert_mask;
		logic [MASK_W-1:0] last_a;
		logic [POS_W-1:0]  position [NUM_CHANNELS];
		int                window_count [NUM_CHANNELS];
		longint            filter_q8 [NUM_CHANNELS];
		speed_report_t     pending_reports [$];
		int                errors;
		int                samples;
		int                ticks;
		int                checked;

		function new();
			pulses_per_rev = PPR_RESET;
			windows_per_minute = WPM_RESET;
			filter_keep = KEEP_RESET;
			invert_mask = INV_RESET;
			last_a = '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				position[i] = '0;
				window_count[i] = 0;
				filter_q8[i] = 0;
			end
			errors = 0;
			samples = 0;
			ticks = 0;
			checked = 0;
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PULSES_PER_REV: pulses_per_rev = data[RATE_W-1:0];
				REG_WINDOWS_PER_MINUTE: windows_per_minute = data[RATE_W-1:0];
				REG_FILTER_KEEP: filter_keep = data[KEEP_W-1:0];
				REG_INVERT_MASK: invert_mask = data[MASK_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_item(logic cmd, logic [MASK_W-1:0] a, logic [MASK_W-1:0] b);
			speed_report_t rep;
			longint        rpm;
			longint        acc;
			longint        keep;
			bit            up;
			if (cmd == CMD_SAMPLE) begin
				samples++;
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					if (a[i] && !last_a[i]) begin
						up = b[i] ^ invert_mask[i];
						if (up) begin
							position[i] = position[i] + 1'b1;
							if (window_count[i] < WIN_MAX) window_count[i]++;
						end else begin
							position[i] = position[i] - 1'b1;
							if (window_count[i] > WIN_MIN) window_count[i]--;
						end
					end
				end
				last_a = a;
				return;
			end
			ticks++;
			keep = (filter_keep > KEEP_FULL) ? 256 : longint'(filter_keep);
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				rpm = 0;
				// zero divisor reads as zero rpm
				if (pulses_per_rev != 0)
					rpm = (longint'(window_count[i]) / longint'(pulses_per_rev)) *
						longint'(windows_per_minute);
				if (rpm > RPM_MAX) rpm = RPM_MAX;
				else if (rpm < RPM_MIN) rpm = RPM_MIN;
				window_count[i] = 0;
				acc = keep * filter_q8[i] + (256 - keep) * rpm * 256;
				filter_q8[i] = acc >>> Q_FRAC_W;
				if (filter_q8[i] > FILT_MAX) filter_q8[i] = FILT_MAX;
				else if (filter_q8[i] < FILT_MIN) filter_q8[i] = FILT_MIN;
				rep.position[i] = position[i];
				rep.speed[i] = rpm[POS_W-1:0];
				// output drops the fraction toward zero, unlike the update
				rep.smoothed[i] = 32'(filter_q8[i] / 256);
			end
			pending_reports.push_back(rep);
		endfunction

		task check_report(speed_report_t got);
			speed_report_t want;
			if (pending_reports.size() == 0) begin
				report_mismatch("report arrived with none expected");
				return;
			end
			want = pending_reports.pop_front();
			checked++;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (got.position[i] !== want.position[i])
					report_mismatch($sformatf("report %0d position_%0d got %0d want %0d", checked,
						i, $signed(got.position[i]), $signed(want.position[i])));
				if (got.speed[i] !== want.speed[i])
					report_mismatch($sformatf("report %0d speed_%0d got %0d want %0d", checked,
						i, $signed(got.speed[i]), $signed(want.speed[i])));
				if (got.smoothed[i] !== want.smoothed[i])
					report_mismatch($sformatf("report %0d smoothed_%0d got %0d want %0d", checked,
						i, $signed(got.smoothed[i]), $signed(want.smoothed[i])));
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	qesm_in_if  items_if ();
	qesm_out_if results_if ();

	rpm_scoreboard sb;
	int            in_idle_pct;
	int            out_idle_pct;
	int            hold_cycles;
	int            settings_count;

	quad_encoder_speed_meter #(
		.WINDOW_WIDTH(WINDOW_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if),
		.results(results_if),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

	// receiver: random stalls, or a long hold-off when asked
	initial begin
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				results_if.ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else begin
				results_if.ready <= ($urandom_range(99) >= out_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		speed_report_t seen;
		if (arst_n && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
			seen.position = {results_if.position_3, results_if.position_2,
				results_if.position_1, results_if.position_0};
			seen.speed = {results_if.speed_3, results_if.speed_2,
				results_if.speed_1, results_if.speed_0};
			seen.smoothed = {results_if.smoothed_3, results_if.smoothed_2,
				results_if.smoothed_1, results_if.smoothed_0};
			sb.check_report(seen);
		end
	end

	// valid stays high after acceptance unless a gap follows
	task automatic send_item(input logic cmd, input logic [MASK_W-1:0] a,
			input logic [MASK_W-1:0] b);
		if ($urandom_range(99) < in_idle_pct) begin
			items_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
		end
		items_if.valid <= 1'b1;
		items_if.command <= cmd;
		items_if.phase_a <= a;
		items_if.phase_b <= b;
		do @(posedge clk); while (items_if.ready !== 1'b1);
		sb.note_item(cmd, a, b);
	endtask

	task automatic wait_quiet();
		items_if.valid <= 1'b0;
		while (sb.pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] ppr,
			input logic [CFG_DATA_W-1:0] wpm, input logic [CFG_DATA_W-1:0] keep,
			input logic [CFG_DATA_W-1:0] mask);
		logic [CFG_IDX_W-1:0]  idx [4] = '{REG_PULSES_PER_REV, REG_WINDOWS_PER_MINUTE,
			REG_FILTER_KEEP, REG_INVERT_MASK};
		logic [CFG_DATA_W-1:0] vals [4];
		vals = '{ppr, wpm, keep, mask};
		for (int r = 0; r < 4; r++) begin
			wr_en <= 1'b1;
			wr_index <= idx[r];
			wr_data <= vals[r];
			@(posedge clk);
			sb.write_reg(idx[r], vals[r]);
		end
		wr_en <= 1'b0;
		settings_count++;
	endtask

	// gray-coded motion per channel, with some noise samples and ticks mixed in
	task automatic run_motion(input int count);
		int                gray [NUM_CHANNELS];
		int                vel [NUM_CHANNELS];
		int                since_tick;
		logic [MASK_W-1:0] a;
		logic [MASK_W-1:0] b;
		since_tick = 0;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			gray[c] = $urandom_range(3);
			vel[c] = int'($urandom_range(2)) - 1;
		end
		for (int n = 0; n < count; n++) begin
			if (since_tick > 60 || (since_tick > 3 && $urandom_range(99) < 8)) begin
				send_item(CMD_TICK, 4'($urandom), 4'($urandom));
				since_tick = 0;
				for (int c = 0; c < NUM_CHANNELS; c++)
					vel[c] = int'($urandom_range(2)) - 1;
			end else begin
				since_tick++;
				if ($urandom_range(9) == 0) begin
					send_item(CMD_SAMPLE, 4'($urandom), 4'($urandom));
				end else begin
					for (int c = 0; c < NUM_CHANNELS; c++) begin
						if ($urandom_range(3) != 0) gray[c] = (gray[c] + vel[c] + 4) % 4;
						a[c] = (gray[c] == 1 || gray[c] == 2);
						b[c] = (gray[c] >= 2);
					end
					send_item(CMD_SAMPLE, a, b);
				end
			end
		end
	endtask

	initial begin
		sb = new();
		in_idle_pct = 19;
		out_idle_pct = 87;
		hold_cycles = 0;
		settings_count = 0;
		arst_n = 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		items_if.valid <= 1'b0;
		items_if.command <= CMD_SAMPLE;
		items_if.phase_a <= '0;
		items_if.phase_b <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: empty window, all edges, held A, falling A, mixed lanes
		send_item(CMD_TICK, 4'h0, 4'h0);
		send_item(CMD_SAMPLE, 4'hF, 4'hF);
		send_item(CMD_SAMPLE, 4'hF, 4'h0);
		send_item(CMD_SAMPLE, 4'h0, 4'h0);
		send_item(CMD_SAMPLE, 4'hF, 4'h0);
		send_item(CMD_SAMPLE, 4'h0, 4'hF);
		send_item(CMD_SAMPLE, 4'h5, 4'hA);
		send_item(CMD_SAMPLE, 4'h0, 4'h0);
		send_item(CMD_SAMPLE, 4'hA, 4'h5);
		send_item(CMD_TICK, 4'hF, 4'hF);

		// long receiver hold-off while ticks keep coming
		hold_cycles = 600;
		for (int k = 0; k < 4; k++) begin
			send_item(CMD_TICK, 4'($urandom), 4'($urandom));
			send_item(CMD_SAMPLE, 4'h3, 4'h1);
			send_item(CMD_SAMPLE, 4'h0, 4'h0);
		end
		run_motion(170);

		wait_quiet();
		program_regs(16'd1, 16'd65535, 16'd0, 16'd0);
		// one-way edges on the low channels, both directions with the mask cleared
		for (int k = 0; k < 28; k++) begin
			send_item(CMD_SAMPLE, 4'h3, 4'h1);
			send_item(CMD_SAMPLE, 4'h0, 4'h1);
		end
		send_item(CMD_TICK, 4'h0, 4'h0);
		send_item(CMD_TICK, 4'h0, 4'h0);
		run_motion(180);

		wait_quiet();
		in_idle_pct = 87;
		out_idle_pct = 19;
		program_regs(16'd65535, 16'd1, 16'd256, 16'hFFFF);
		run_motion(180);

		wait_quiet();
		// zero divisor and keep above full scale
		program_regs(16'd0, 16'($urandom), 16'd511, 16'd5);
		run_motion(180);

		wait_quiet();
		in_idle_pct = 0;
		out_idle_pct = 0;
		program_regs(16'd3, 16'd60, 16'd257, 16'd10);
		run_motion(180);

		wait_quiet();
		program_regs(16'($urandom_range(1, 8)), 16'($urandom), 16'($urandom),
			16'($urandom));
		run_motion(180);

		wait_quiet();
		$display("covered %0d pin samples and %0d ticks over %0d register settings",
			sb.samples, sb.ticks, settings_count);
		$display("compared %0d reports, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
